// File: design/bidt_pkg.sv
package bidt_pkg;

  // Number of entries in the duplicate table.
  localparam int unsigned TABLE_DEPTH = 64;
  // Index into the table, and a count that can also hold TABLE_DEPTH itself.
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    OUT_INSERTED  = 2'd0,
    OUT_UPDATED   = 2'd1,
    OUT_DUPLICATE = 2'd2,
    OUT_FULL      = 2'd3
  } outcome_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  // One route-request record; also the layout of a stored table entry.
  typedef struct packed {
    logic [31:0] source_address;
    logic [31:0] broadcast_id;
    logic [7:0]  hops;
  } req_t;

  typedef struct packed {
    logic     send_reply;
    outcome_e outcome;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_req;
    logic     scan_step;
    logic     wr_en;
    logic     wr_insert;
    logic     load_rsp;
    logic     reply;
    outcome_e outcome;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic better;
    logic done_miss;
    logic full;
    logic slot_free;
  } status_t;

endpackage

// File: design/broadcast_id_duplicate_table.sv
// Duplicate cache for route requests, keyed on source address and broadcast id.
// Input channel: in_valid_i / in_stall_o with an in_data_i record (source
// address, broadcast id, hop count). A transfer happens at a rising edge where
// valid is high and stall is low. Output channel: out_valid_o / out_stall_i
// with out_data_o (send_reply, outcome), exactly one result per record.
// One record is handled at a time. After a transfer the valid table entries
// are read one per cycle through a registered read and compared with the
// record; a match ends the scan early, otherwise the result is posted once
// every entry in use has been compared. The block is ready for the next
// record as soon as its result is in the output register.
// A finished result sits in an output register, so the next record is taken
// while an earlier result still waits; a stalled receiver only holds back the
// completion of the record after that.
// Reset empties the table (fill count zero) and clears the output valid flag;
// the table memory itself is not cleared and needs no clearing pass.
module broadcast_id_duplicate_table (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  bidt_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output bidt_pkg::rsp_t out_data_o
);
  import bidt_pkg::*;

  // Command and status bundles between the sequencer and the table datapath.
  cmd_t    cmd;
  status_t status;

  bidt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the table, fill count, scan pointer and result register.
  bidt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_stall_i (out_stall_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// File: design/bidt_dp.sv
module bidt_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bidt_pkg::req_t   in_data_i,
  input  bidt_pkg::cmd_t   cmd_i,
  input  logic             out_stall_i,
  output bidt_pkg::status_t status_o,
  output logic             out_valid_o,
  output bidt_pkg::rsp_t   out_data_o
);
  import bidt_pkg::*;

  req_t             mem [TABLE_DEPTH];
  req_t             req_q;
  req_t             rd_data_q;
  logic [IDX_W-1:0] cmp_idx_q;
  logic             cmp_vld_q, cmp_vld_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
  logic             out_vld_q, out_vld_d;
  rsp_t             rsp_q;
  logic             rd_more;
  logic             match;
  logic [IDX_W-1:0] wr_addr;

  assign rd_more = rd_idx_q < fill_q;
  assign match   = (rd_data_q.source_address == req_q.source_address) &&
                   (rd_data_q.broadcast_id == req_q.broadcast_id);
  assign wr_addr = cmd_i.wr_insert ? fill_q[IDX_W-1:0] : cmp_idx_q;

  always_comb begin
    rd_idx_d  = rd_idx_q;
    cmp_vld_d = cmp_vld_q;
    if (cmd_i.load_req) begin
      rd_idx_d  = '0;
      cmp_vld_d = 1'b0;
    end else if (cmd_i.scan_step) begin
      cmp_vld_d = rd_more;
      if (rd_more) begin
        rd_idx_d = rd_idx_q + CNT_W'(1);
      end
    end

    fill_d = fill_q;
    if (cmd_i.wr_en && cmd_i.wr_insert) begin
      fill_d = fill_q + CNT_W'(1);
    end

    out_vld_d = out_vld_q;
    if (cmd_i.load_rsp) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
      fill_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      rd_idx_q  <= rd_idx_d;
      cmp_vld_q <= cmp_vld_d;
      fill_q    <= fill_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_data_i;
    end
    if (cmd_i.load_rsp) begin
      rsp_q.send_reply <= cmd_i.reply;
      rsp_q.outcome    <= cmd_i.outcome;
    end
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr] <= req_q;
    end
    if (cmd_i.scan_step && rd_more) begin
      rd_data_q <= mem[rd_idx_q[IDX_W-1:0]];
      cmp_idx_q <= rd_idx_q[IDX_W-1:0];
    end
  end

  assign status_o.hit       = cmp_vld_q && match;
  assign status_o.better    = rd_data_q.hops > req_q.hops;
  assign status_o.done_miss = !rd_more && !cmp_vld_q;
  assign status_o.full      = fill_q == CNT_W'(TABLE_DEPTH);
  assign status_o.slot_free = !out_vld_q || !out_stall_i;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = rsp_q;

endmodule

// File: design/bidt_ctrl.sv
module bidt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bidt_pkg::status_t status_i,
  output bidt_pkg::cmd_t    cmd_o
);
  import bidt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_stall_o    = 1'b1;
    cmd_o         = '0;
    cmd_o.outcome = OUT_INSERTED;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.hit || status_i.done_miss) begin
          // Scan is over; finish once the result register can take the result.
          if (status_i.slot_free) begin
            cmd_o.load_rsp = 1'b1;
            state_d        = ST_IDLE;
            if (status_i.hit) begin
              if (status_i.better) begin
                cmd_o.wr_en   = 1'b1;
                cmd_o.reply   = 1'b1;
                cmd_o.outcome = OUT_UPDATED;
              end else begin
                cmd_o.outcome = OUT_DUPLICATE;
              end
            end else if (status_i.full) begin
              cmd_o.outcome = OUT_FULL;
            end else begin
              cmd_o.wr_en     = 1'b1;
              cmd_o.wr_insert = 1'b1;
              cmd_o.reply     = 1'b1;
              cmd_o.outcome   = OUT_INSERTED;
            end
          end
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: design/bidt_checker.sv
module bidt_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input bidt_pkg::rsp_t out_data_o
);
  import bidt_pkg::*;

  // A taken record keeps the block busy for at least the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a transfer");

  // A new result only appears while a record is being worked on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared with no record in flight");

  // A reply is requested exactly for insertions and better routes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.send_reply ==
      (out_data_o.outcome == OUT_INSERTED || out_data_o.outcome == OUT_UPDATED)))
    else $error("send_reply does not match outcome");

  // A stalled result stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind broadcast_id_duplicate_table bidt_checker u_bidt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import bidt_pkg::*;

  // Cycles without any transfer on either channel before the run is abandoned.
  // The slowest correct record scans the full table, and a receiver that
  // stalls 80 percent of the time can add a long random tail.
  localparam int unsigned QUIET_LIMIT = 2000;
  // Cycles allowed after the last expected result before the run ends.
  // This covers one full-table scan with margin.
  localparam int unsigned DRAIN_CYCLES = 100;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Request side, driven by the sender below.
  logic req_valid = 1'b0;
  req_t req_data = '0;
  logic req_stall;

  // Reply side, driven by the receiver below.
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp_data;

  // Requests waiting to be offered, and replies the block still owes us.
  req_t pending_reqs[$];
  rsp_t expected_replies[$];

  // Idle odds in percent for each side. They change only between phases.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  int unsigned mismatch_count = 0;
  int unsigned requests_taken = 0;
  int unsigned outcome_tally[4] = '{default: 0};
  int unsigned quiet_cycles = 0;

  // Our own copy of the duplicate table. Only the first known_fill entries are
  // ever read, just as in the block.
  logic [31:0] known_src[TABLE_DEPTH];
  logic [31:0] known_bid[TABLE_DEPTH];
  logic [7:0] known_hops[TABLE_DEPTH];
  int unsigned known_fill = 0;

  // Pairs the stimulus has already sent, with the lowest hop count sent for
  // each. The generator reuses them to hit matches, equal hop counts and
  // better routes. Pairs refused by a full table also land here.
  logic [31:0] sent_src[$];
  logic [31:0] sent_bid[$];
  logic [7:0] sent_min_hops[$];

  rsp_t oldest_reply;

  broadcast_id_duplicate_table dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_valid),
    .in_stall_o (req_stall),
    .in_data_i  (req_data),
    .out_valid_o(rsp_valid),
    .out_stall_i(rsp_stall),
    .out_data_o (rsp_data)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Look up one route request in the table and work out the reply. A match
  // with a larger stored hop count lowers it. A match with an equal or smaller
  // stored count is a duplicate. A new pair is appended unless the table is
  // full, in which case it is dropped.
  function automatic rsp_t dup_table_lookup(req_t r);
    rsp_t res;
    res.send_reply = 1'b0;
    res.outcome = OUT_DUPLICATE;
    for (int k = 0; k < known_fill; k++) begin
      if (known_src[k] == r.source_address && known_bid[k] == r.broadcast_id) begin
        if (known_hops[k] > r.hops) begin
          known_hops[k] = r.hops;
          res.send_reply = 1'b1;
          res.outcome = OUT_UPDATED;
        end
        return res;
      end
    end
    if (known_fill >= TABLE_DEPTH) begin
      res.outcome = OUT_FULL;
      return res;
    end
    known_src[known_fill] = r.source_address;
    known_bid[known_fill] = r.broadcast_id;
    known_hops[known_fill] = r.hops;
    known_fill++;
    res.send_reply = 1'b1;
    res.outcome = OUT_INSERTED;
    return res;
  endfunction

  // Record a request in the list of sent pairs, then queue it for the sender.
  task automatic queue_request(input logic [31:0] addr, input logic [31:0] bid,
                               input logic [7:0] hops);
    req_t r;
    bit found;
    r.source_address = addr;
    r.broadcast_id = bid;
    r.hops = hops;
    found = 1'b0;
    foreach (sent_src[j]) begin
      if (!found && sent_src[j] == addr && sent_bid[j] == bid) begin
        found = 1'b1;
        if (hops < sent_min_hops[j]) sent_min_hops[j] = hops;
      end
    end
    if (!found) begin
      sent_src.push_back(addr);
      sent_bid.push_back(bid);
      sent_min_hops.push_back(hops);
    end
    pending_reqs.push_back(r);
  endtask

  // Most random requests are copies of a pair already sent, since that is
  // where updates and duplicates happen. A smaller share brings new pairs,
  // some of which share one half of the key with a known pair. The new pairs
  // fill the table partway through the run, so later ones see it full.
  task automatic queue_random_request();
    int unsigned pick;
    int unsigned j;
    logic [31:0] addr;
    logic [31:0] bid;
    logic [7:0] hops;
    pick = $urandom_range(99);
    hops = 8'($urandom_range(255));
    if (pick < 8) begin
      addr = $urandom();
      bid = $urandom();
    end else begin
      j = $urandom_range(sent_src.size() - 1);
      addr = sent_src[j];
      bid = sent_bid[j];
      if (pick < 11) begin
        bid = $urandom();
      end else if (pick < 14) begin
        addr = $urandom();
      end else if (pick < 28) begin
        // Same hop count as the stored one: a duplicate with no reply.
        hops = sent_min_hops[j];
      end else if (pick < 45) begin
        // One hop better than the stored route, unless it is already zero.
        hops = sent_min_hops[j] - 8'd1;
      end
    end
    queue_request(addr, bid, hops);
  endtask

  // Hold the sender back until the block has answered everything it took.
  task automatic wait_until_drained();
    while (pending_reqs.size() != 0 || req_valid || expected_replies.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Sender. A request is predicted at the edge where its transfer happens.
  // A new request is loaded only when the slot is empty or was just taken,
  // so a stalled request never changes.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        expected_replies.push_back(dup_table_lookup(req_data));
        requests_taken++;
      end
      if (!req_valid || !req_stall) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_data <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Every reply transfer is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_replies.size() == 0) begin
          $error("reply with none expected: send_reply %0d outcome %0d",
                 rsp_data.send_reply, rsp_data.outcome);
          mismatch_count++;
        end else begin
          oldest_reply = expected_replies.pop_front();
          outcome_tally[oldest_reply.outcome]++;
          if (rsp_data.send_reply !== oldest_reply.send_reply) begin
            $error("send_reply: expected %0d, got %0d",
                   oldest_reply.send_reply, rsp_data.send_reply);
            mismatch_count++;
          end
          if (rsp_data.outcome !== oldest_reply.outcome) begin
            $error("outcome: expected %0d, got %0d",
                   oldest_reply.outcome, rsp_data.outcome);
            mismatch_count++;
          end
        end
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: a run that goes quiet for too long is a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $error("no transfer for %0d cycles, %0d replies outstanding",
               quiet_cycles, expected_replies.size());
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    // First phase: the sender rarely idles while the receiver mostly stalls,
    // so a finished reply often waits in the output register.
    send_idle_pct = 15;
    recv_idle_pct = 80;

    // Directed requests: key and hop count extremes, equal, larger and
    // smaller hop counts on a match, and pairs that match on one half only.
    queue_request(32'h0000_0000, 32'h0000_0000, 8'd255);
    queue_request(32'h0000_0000, 32'h0000_0000, 8'd255);
    queue_request(32'h0000_0000, 32'h0000_0000, 8'd254);
    queue_request(32'h0000_0000, 32'h0000_0000, 8'd0);
    queue_request(32'h0000_0000, 32'h0000_0000, 8'd0);
    queue_request(32'h0000_0000, 32'h0000_0000, 8'd255);
    queue_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0);
    queue_request(32'hFFFF_FFFF, 32'h0000_0000, 8'd128);
    queue_request(32'h0000_0000, 32'hFFFF_FFFF, 8'd1);
    queue_request(32'h0000_0000, 32'hFFFF_FFFF, 8'd0);
    queue_request(32'hAAAA_AAAA, 32'h5555_5555, 8'hAA);
    queue_request(32'h5555_5555, 32'hAAAA_AAAA, 8'h55);
    queue_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);
    queue_request(32'hFFFF_FFFF, 32'h0000_0000, 8'd127);
    queue_request(32'h5555_5555, 32'hAAAA_AAAA, 8'h55);
    for (int n = 0; n < 235; n++) queue_random_request();

    // The sender pauses here until every reply has come back.
    wait_until_drained();

    // Second phase: the sender mostly idles while the receiver rarely stalls.
    send_idle_pct = 80;
    recv_idle_pct = 15;
    for (int n = 0; n < 235; n++) queue_random_request();
    wait_until_drained();

    // Last phase: back-to-back traffic with no idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int n = 0; n < 230; n++) queue_random_request();
    wait_until_drained();

    // Give a stray extra reply time to show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_replies.size() != 0) begin
      $error("%0d replies never arrived", expected_replies.size());
      mismatch_count++;
    end

    $display("Covered %0d route requests: %0d inserted, %0d better routes, %0d duplicates,",
             requests_taken, outcome_tally[OUT_INSERTED], outcome_tally[OUT_UPDATED],
             outcome_tally[OUT_DUPLICATE]);
    $display("%0d refused by a full table; the table ended with %0d of %0d entries in use.",
             outcome_tally[OUT_FULL], known_fill, TABLE_DEPTH);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/bidt_pkg.sv
design/bidt_dp.sv
design/bidt_ctrl.sv
design/broadcast_id_duplicate_table.sv
design/bidt_checker.sv
dv/testbench.sv
